[sv/b64d_pkg.sv]
`default_nettype none
package b64d_pkg;

  // One queued job: the results that one character causes
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [1:0] nbytes;
    logic       has_end;
    logic       end_status;
  } job_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  localparam logic [5:0] OFS_LOWER = 6'd26;
  localparam logic [5:0] OFS_DIGIT = 6'd52;
  localparam logic [5:0] VAL_PLUS  = 6'd62;
  localparam logic [5:0] VAL_SLASH = 6'd63;

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    logic [7:0] d;
    s = '0;
    d = '0;
    if (c >= "A" && c <= "Z") begin
      d = c - 8'("A");
      s = '{ok: 1'b1, val: d[5:0]};
    end else if (c >= "a" && c <= "z") begin
      d = c - 8'("a");
      s = '{ok: 1'b1, val: d[5:0] + OFS_LOWER};
    end else if (c >= "0" && c <= "9") begin
      d = c - 8'("0");
      s = '{ok: 1'b1, val: d[5:0] + OFS_DIGIT};
    end else if (c == CHAR_PLUS) begin
      s = '{ok: 1'b1, val: VAL_PLUS};
    end else if (c == CHAR_SLASH) begin
      s = '{ok: 1'b1, val: VAL_SLASH};
    end
    sextet_of = s;
  endfunction

endpackage
`default_nettype wire

[sv/b64d_in_if.sv]
`default_nettype none
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_string;

  modport source (output valid, output char_code, output end_of_string, input ready);
  modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface
`default_nettype wire

[sv/b64d_out_if.sv]
`default_nettype none
interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       run_last;
  logic       string_done;
  logic       status;

  modport source (output valid, output data_byte, output byte_valid, output run_last,
                  output string_done, output status, input ready);
  modport sink   (input valid, input data_byte, input byte_valid, input run_last,
                  input string_done, input status, output ready);
endinterface
`default_nettype wire

[sv/base64_stream_decoder.sv]
// channel  dir  word
// in_ch    in   char_code, end_of_string
// out_ch   out  data_byte, byte_valid, run_last, string_done, status
//
// One character is taken per cycle while the job queue between front and
// back has room; the back end sends one word per cycle unless out_ch.ready
// is low, so a full group gives up to three words (four with the end word).
// Results pass the queue and then the output register. Reset is synchronous
// and empties the queue and output register. Output stalls back up through
// the queue to in_ch.ready only once the queue is full.
`default_nettype none
module base64_stream_decoder #(
  parameter int QueueDepth = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  b64d_in_if.sink    in_ch,
  b64d_out_if.source out_ch
);
  import b64d_pkg::*;

  job_t job, head_job;
  logic push, full, pop, head_valid, accept;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;

  b64d_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .char_code     (in_ch.char_code),
    .end_of_string (in_ch.end_of_string),
    .job           (job),
    .push          (push)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

[sv/b64d_front.sv]
`default_nettype none
module b64d_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    char_code,
  input  wire logic          end_of_string,
  output b64d_pkg::job_t     job,
  output logic               push
);
  import b64d_pkg::*;

  logic [1:0] pos_r, pos_nxt;
  logic [5:0] v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  logic       v3ok_r, v3ok_nxt;
  logic       halted_r, halted_nxt;
  logic       any_r, any_nxt;
  sextet_t    sx;

  always_comb begin
    sx         = sextet_of(char_code);
    pos_nxt    = pos_r;
    v1_nxt     = v1_r;
    v2_nxt     = v2_r;
    v3_nxt     = v3_r;
    v3ok_nxt   = v3ok_r;
    halted_nxt = halted_r;
    any_nxt    = any_r;
    job        = '0;
    job.byte0  = {v1_r, v2_r[5:4]};
    job.byte1  = {v2_r[3:0], v3_r[5:2]};
    job.byte2  = {v3_r[1:0], sx.val};

    if (!halted_r && !is_blank(char_code)) begin
      if (!pos_r[1] && !sx.ok) begin
        // bad first or second value: stop until end of string
        halted_nxt = 1'b1;
        pos_nxt    = 2'd0;
      end else if (pos_r != 2'd3) begin
        case (pos_r)
          2'd0:    v1_nxt = sx.val;
          2'd1:    v2_nxt = sx.val;
          default: begin
            v3_nxt   = sx.val;
            v3ok_nxt = sx.ok;
          end
        endcase
        pos_nxt = pos_r + 2'd1;
      end else begin
        job.nbytes = v3ok_r ? (sx.ok ? 2'd3 : 2'd2) : 2'd1;
        any_nxt    = 1'b1;
        pos_nxt    = 2'd0;
      end
    end

    if (end_of_string) begin
      job.has_end    = 1'b1;
      job.end_status = !any_nxt;
      pos_nxt        = 2'd0;
      halted_nxt     = 1'b0;
      any_nxt        = 1'b0;
      v3ok_nxt       = 1'b0;
    end

    push = accept && (job.nbytes != 2'd0 || job.has_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      v3ok_r   <= 1'b0;
      halted_r <= 1'b0;
      any_r    <= 1'b0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      v3ok_r   <= v3ok_nxt;
      halted_r <= halted_nxt;
      any_r    <= any_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/b64d_queue.sv]
`default_nettype none
module b64d_queue #(
  parameter int Depth = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire b64d_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output b64d_pkg::job_t      head_job
);
  import b64d_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            mem_r [Depth];
  logic [PtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CntFull);
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? ((wr_r == PtrMax) ? '0 : wr_r + 1'b1) : wr_r;
    rd_nxt  = pop  ? ((rd_r == PtrMax) ? '0 : rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

[sv/b64d_back.sv]
`default_nettype none
module b64d_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           head_valid,
  input  wire b64d_pkg::job_t head_job,
  output logic                pop,
  b64d_out_if.source          out_ch
);
  import b64d_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       bval_r, bval_nxt;
  logic       last_r, last_nxt;
  logic       done_r, done_nxt;
  logic       stat_r, stat_nxt;
  logic       load;
  logic [2:0] total;

  assign out_ch.valid       = valid_r;
  assign out_ch.data_byte   = byte_r;
  assign out_ch.byte_valid  = bval_r;
  assign out_ch.run_last    = last_r;
  assign out_ch.string_done = done_r;
  assign out_ch.status      = stat_r;

  always_comb begin
    total     = {1'b0, head_job.nbytes} + {2'b00, head_job.has_end};
    load      = head_valid && (!valid_r || out_ch.ready);
    last_nxt  = ({1'b0, idx_r} + 3'd1 == total);
    pop       = load && last_nxt;
    idx_nxt   = idx_r;
    valid_nxt = valid_r && !out_ch.ready;
    byte_nxt  = byte_r;
    bval_nxt  = bval_r;
    done_nxt  = done_r;
    stat_nxt  = stat_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = pop ? 2'd0 : idx_r + 2'd1;
      if (idx_r < head_job.nbytes) begin
        case (idx_r)
          2'd0:    byte_nxt = head_job.byte0;
          2'd1:    byte_nxt = head_job.byte1;
          default: byte_nxt = head_job.byte2;
        endcase
        bval_nxt = 1'b1;
        done_nxt = 1'b0;
        stat_nxt = 1'b0;
      end else begin
        // end word closes the string
        byte_nxt = '0;
        bval_nxt = 1'b0;
        done_nxt = 1'b1;
        stat_nxt = head_job.end_status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      bval_r <= bval_nxt;
      last_r <= last_nxt;
      done_r <= done_nxt;
      stat_r <= stat_nxt;
    end
  end

endmodule
`default_nettype wire
